// ----- hdl/firmware_update_handshake_fsm_unit_macros.svh -----
// assertion macros for the firmware update handshake unit
// no dependencies; taken in by files that carry concurrent checks
`ifndef FIRMWARE_UPDATE_HANDSHAKE_FSM_UNIT_MACROS_SVH
`define FIRMWARE_UPDATE_HANDSHAKE_FSM_UNIT_MACROS_SVH

// same-cycle implication check
`define FWU_ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication check
`define FWU_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- hdl/fwu_pkg.sv -----
// shared types and constants of the firmware update handshake unit
// no dependencies
package fwu_pkg;

   // packet window size and byte count width
   localparam logic [5:0] PACKET_BYTES = 6'd16;
   localparam int         CNT_W        = 6;

   // session phases
   localparam logic [2:0] PH_SYNC       = 3'd0;
   localparam logic [2:0] PH_UPDATE_REQ = 3'd1;
   localparam logic [2:0] PH_ID_CHECK   = 3'd2;
   localparam logic [2:0] PH_LENGTH     = 3'd3;
   localparam logic [2:0] PH_RECEIVE    = 3'd4;
   localparam logic [2:0] PH_DONE       = 3'd5;

   // input item kinds
   localparam logic [1:0] KIND_RAW    = 2'd0;
   localparam logic [1:0] KIND_PACKET = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;

   // result actions
   localparam logic [1:0] ACT_REPLY = 2'd0;
   localparam logic [1:0] ACT_ERASE = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;

   // reply codes
   localparam logic [2:0] RC_SYNC      = 3'd0;
   localparam logic [2:0] RC_UPDATE_OK = 3'd1;
   localparam logic [2:0] RC_ID_REQ    = 3'd2;
   localparam logic [2:0] RC_LEN_REQ   = 3'd3;
   localparam logic [2:0] RC_READY     = 3'd4;
   localparam logic [2:0] RC_SUCCESS   = 3'd5;
   localparam logic [2:0] RC_NACK      = 3'd6;

   // register indexes
   localparam logic [2:0] REG_TIMEOUT   = 3'd0;
   localparam logic [2:0] REG_DEV_IDENT = 3'd1;
   localparam logic [2:0] REG_MAX_LEN   = 3'd2;
   localparam logic [2:0] REG_APP_BASE  = 3'd3;
   localparam logic [2:0] REG_CODE_UPD  = 3'd4;
   localparam logic [2:0] REG_CODE_ID   = 3'd5;
   localparam logic [2:0] REG_CODE_LEN  = 3'd6;

   // register reset values
   localparam logic [15:0] RST_TIMEOUT   = 16'd5000;
   localparam logic [7:0]  RST_DEV_IDENT = 8'h42;
   localparam logic [20:0] RST_MAX_LEN   = 21'd114688;
   localparam logic [31:0] RST_APP_BASE  = 32'd134234112;
   localparam logic [7:0]  RST_CODE_UPD  = 8'd1;
   localparam logic [7:0]  RST_CODE_ID   = 8'd2;
   localparam logic [7:0]  RST_CODE_LEN  = 8'd3;

   // sync pattern and fill byte
   localparam logic [31:0] SYNC_PATTERN = 32'hC4557E10;
   localparam logic [7:0]  FILL_BYTE    = 8'hFF;
   localparam logic [15:0] TICKS_MAX    = 16'hFFFF;

   // request packet lengths
   localparam logic [7:0] NEED_UPDATE = 8'd1;
   localparam logic [7:0] NEED_ID     = 8'd2;
   localparam logic [7:0] NEED_LENGTH = 8'd5;

   // one result item
   typedef struct packed {
      logic [1:0]  action;
      logic [2:0]  reply_code;
      logic [31:0] write_address;
      logic [7:0]  write_data;
      logic        finished;
      logic        last_result;
   } result_type;

   // reply result with no write payload
   function automatic result_type make_reply(logic [1:0] act, logic [2:0] code,
                                             logic fin);
      result_type r;
      r               = '0;
      r.action        = act;
      r.reply_code    = code;
      r.finished      = fin;
      return r;
   endfunction

endpackage

// ----- hdl/firmware_update_handshake_fsm_unit.sv -----
// top level of the firmware update handshake unit: registers, phase logic,
// result queue; depends on fwu_pkg and firmware_update_handshake_fsm_unit_macros.svh

// The unit takes one item per clock into an input register while the result
// queue has room, evaluates it there against the session state and pushes zero,
// one or two results into a four-entry result queue that drives the rsp_ channel.
// Items giving one result or none sustain one item per cycle while rsp_ready is
// high, while items giving two results are paced by the result port, which
// delivers one transfer per cycle while rsp_ready is high. The input register moves on
// whenever the queue holds two or fewer results. Registers sit on an APB-style
// port at byte address 4*i, always ready; write them only while the unit is idle.
`include "firmware_update_handshake_fsm_unit_macros.svh"

module firmware_update_handshake_fsm_unit (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_byte_value,
   input  logic [3:0]  req_byte_index,
   input  logic [7:0]  req_length_field,
   input  logic        req_last_byte,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_action,
   output logic [2:0]  rsp_reply_code,
   output logic [31:0] rsp_write_address,
   output logic [7:0]  rsp_write_data,
   output logic        rsp_finished,
   output logic        rsp_last_result,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // configuration registers
   logic [15:0] timeout_ff;
   logic [7:0]  dev_ident_ff;
   logic [20:0] max_len_ff;
   logic [31:0] app_base_ff;
   logic [7:0]  code_upd_ff;
   logic [7:0]  code_id_ff;
   logic [7:0]  code_len_ff;

   // input register
   logic        in_valid_ff;
   logic [1:0]  in_kind_ff;
   logic [7:0]  in_value_ff;
   logic [3:0]  in_index_ff;
   logic [7:0]  in_length_ff;
   logic        in_last_ff;

   // session state
   logic [2:0]  phase_ff,        phase_in;
   logic [31:0] window_ff,       window_in;
   logic [15:0] idle_ff,         idle_in;
   logic [31:0] image_len_ff,    image_len_in;
   logic [31:0] bytes_done_ff,   bytes_done_in;
   logic        pkt_ok_ff,       pkt_ok_in;

   // result queue
   fwu_pkg::result_type q_ff [4];
   logic [1:0]  head_ff;
   logic [1:0]  tail_ff;
   logic [2:0]  count_ff;

   // evaluation outputs
   fwu_pkg::result_type res0, res1;
   logic [1:0]  res_n;
   logic        proc_fire;
   logic        pop;
   logic [1:0]  push_n;
   logic        cfg_write;

   assign cfg_write = psel & penable & pwrite & pready;
   assign pready    = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= fwu_pkg::RST_TIMEOUT;
         dev_ident_ff <= fwu_pkg::RST_DEV_IDENT;
         max_len_ff   <= fwu_pkg::RST_MAX_LEN;
         app_base_ff  <= fwu_pkg::RST_APP_BASE;
         code_upd_ff  <= fwu_pkg::RST_CODE_UPD;
         code_id_ff   <= fwu_pkg::RST_CODE_ID;
         code_len_ff  <= fwu_pkg::RST_CODE_LEN;
      end else if (cfg_write) begin
         case (paddr[4:2])
            fwu_pkg::REG_TIMEOUT:   timeout_ff   <= pwdata[15:0];
            fwu_pkg::REG_DEV_IDENT: dev_ident_ff <= pwdata[7:0];
            fwu_pkg::REG_MAX_LEN:   max_len_ff   <= pwdata[20:0];
            fwu_pkg::REG_APP_BASE:  app_base_ff  <= pwdata;
            fwu_pkg::REG_CODE_UPD:  code_upd_ff  <= pwdata[7:0];
            fwu_pkg::REG_CODE_ID:   code_id_ff   <= pwdata[7:0];
            fwu_pkg::REG_CODE_LEN:  code_len_ff  <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (paddr[4:2])
         fwu_pkg::REG_TIMEOUT:   prdata = {16'd0, timeout_ff};
         fwu_pkg::REG_DEV_IDENT: prdata = {24'd0, dev_ident_ff};
         fwu_pkg::REG_MAX_LEN:   prdata = {11'd0, max_len_ff};
         fwu_pkg::REG_APP_BASE:  prdata = app_base_ff;
         fwu_pkg::REG_CODE_UPD:  prdata = {24'd0, code_upd_ff};
         fwu_pkg::REG_CODE_ID:   prdata = {24'd0, code_id_ff};
         fwu_pkg::REG_CODE_LEN:  prdata = {24'd0, code_len_ff};
         default:                prdata = 32'd0;
      endcase
   end

   // input register handshake
   assign proc_fire = in_valid_ff && (count_ff <= 3'd2);
   assign req_ready = !in_valid_ff || proc_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_kind_ff   <= req_kind;
         in_value_ff  <= req_byte_value;
         in_index_ff  <= req_byte_index;
         in_length_ff <= req_length_field;
         in_last_ff   <= req_last_byte;
      end
   end

   // item evaluation against session state
   always_comb begin
      logic [15:0]            idle_sat;
      logic [fwu_pkg::CNT_W-1:0] cnt_raw;
      logic [fwu_pkg::CNT_W-1:0] cnt;
      logic [fwu_pkg::CNT_W-1:0] idx_ext;
      logic [7:0]             need;
      logic [7:0]             code;
      logic                   byte_good;
      logic                   ok;

      phase_in      = phase_ff;
      window_in     = window_ff;
      idle_in       = idle_ff;
      image_len_in  = image_len_ff;
      bytes_done_in = bytes_done_ff;
      pkt_ok_in     = pkt_ok_ff;
      res0          = '0;
      res1          = '0;
      res_n         = 2'd0;

      idle_sat  = (idle_ff < fwu_pkg::TICKS_MAX) ? idle_ff + 16'd1 : idle_ff;
      cnt_raw   = {1'b0, in_length_ff[4:0]} + 1'b1;
      cnt       = (cnt_raw > fwu_pkg::PACKET_BYTES) ? fwu_pkg::PACKET_BYTES : cnt_raw;
      idx_ext   = {{(fwu_pkg::CNT_W-4){1'b0}}, in_index_ff};

      // request packet shape for this phase
      case (phase_ff)
         fwu_pkg::PH_UPDATE_REQ: begin
            need = fwu_pkg::NEED_UPDATE;
            code = code_upd_ff;
         end
         fwu_pkg::PH_ID_CHECK: begin
            need = fwu_pkg::NEED_ID;
            code = code_id_ff;
         end
         default: begin
            need = fwu_pkg::NEED_LENGTH;
            code = code_len_ff;
         end
      endcase

      // per-byte check of a request packet
      if (in_length_ff != need)
         byte_good = 1'b0;
      else if (in_index_ff == 4'd0)
         byte_good = (in_value_ff == code);
      else if ({4'd0, in_index_ff} >= need)
         byte_good = (in_value_ff == fwu_pkg::FILL_BYTE);
      else if (phase_ff == fwu_pkg::PH_ID_CHECK && in_index_ff == 4'd1)
         byte_good = (in_value_ff == dev_ident_ff);
      else
         byte_good = 1'b1;

      ok = 1'b0;

      if (!proc_fire || phase_ff >= fwu_pkg::PH_DONE) begin
         // nothing to do
      end else if (in_kind_ff == fwu_pkg::KIND_TICK) begin
         idle_in = idle_sat;
         if (idle_sat >= timeout_ff) begin
            phase_in = fwu_pkg::PH_DONE;
            res0     = fwu_pkg::make_reply(fwu_pkg::ACT_REPLY, fwu_pkg::RC_NACK, 1'b1);
            res_n    = 2'd1;
         end
      end else if (in_kind_ff == fwu_pkg::KIND_RAW) begin
         if (phase_ff == fwu_pkg::PH_SYNC) begin
            window_in = {window_ff[23:0], in_value_ff};
            if ({window_ff[23:0], in_value_ff} == fwu_pkg::SYNC_PATTERN) begin
               idle_in  = 16'd0;
               phase_in = fwu_pkg::PH_UPDATE_REQ;
               res0     = fwu_pkg::make_reply(fwu_pkg::ACT_REPLY, fwu_pkg::RC_SYNC, 1'b0);
               res_n    = 2'd1;
            end
         end
      end else if (in_kind_ff == fwu_pkg::KIND_PACKET && phase_ff != fwu_pkg::PH_SYNC) begin
         if (phase_ff == fwu_pkg::PH_RECEIVE) begin
            // data packet: flash writes, then verdict on the last byte
            if (idx_ext < cnt) begin
               res0.action        = fwu_pkg::ACT_WRITE;
               res0.write_address = app_base_ff + bytes_done_ff
                                    + {28'd0, in_index_ff};
               res0.write_data    = in_value_ff;
               res_n              = 2'd1;
            end
            if (in_last_ff) begin
               bytes_done_in = bytes_done_ff + {{(32-fwu_pkg::CNT_W){1'b0}}, cnt};
               idle_in       = 16'd0;
               if (bytes_done_ff + {{(32-fwu_pkg::CNT_W){1'b0}}, cnt} >= image_len_ff) begin
                  phase_in = fwu_pkg::PH_DONE;
                  if (res_n == 2'd1)
                     res1 = fwu_pkg::make_reply(fwu_pkg::ACT_REPLY,
                                                fwu_pkg::RC_SUCCESS, 1'b1);
                  else
                     res0 = fwu_pkg::make_reply(fwu_pkg::ACT_REPLY,
                                                fwu_pkg::RC_SUCCESS, 1'b1);
               end else begin
                  if (res_n == 2'd1)
                     res1 = fwu_pkg::make_reply(fwu_pkg::ACT_REPLY,
                                                fwu_pkg::RC_READY, 1'b0);
                  else
                     res0 = fwu_pkg::make_reply(fwu_pkg::ACT_REPLY,
                                                fwu_pkg::RC_READY, 1'b0);
               end
               res_n = res_n + 2'd1;
            end
         end else begin
            // request packet bytes inside the window
            if (idx_ext < fwu_pkg::PACKET_BYTES) begin
               if (!byte_good)
                  pkt_ok_in = 1'b0;
               if (phase_ff == fwu_pkg::PH_LENGTH) begin
                  case (in_index_ff)
                     4'd1:    image_len_in[7:0]   = in_value_ff;
                     4'd2:    image_len_in[15:8]  = in_value_ff;
                     4'd3:    image_len_in[23:16] = in_value_ff;
                     4'd4:    image_len_in[31:24] = in_value_ff;
                     default: ;
                  endcase
               end
            end
            if (in_last_ff) begin
               ok        = pkt_ok_in;
               pkt_ok_in = 1'b1;
               if (phase_ff == fwu_pkg::PH_LENGTH && image_len_in > {11'd0, max_len_ff})
                  ok = 1'b0;
               if (!ok) begin
                  phase_in = fwu_pkg::PH_DONE;
                  res0     = fwu_pkg::make_reply(fwu_pkg::ACT_REPLY, fwu_pkg::RC_NACK, 1'b1);
                  res_n    = 2'd1;
               end else begin
                  idle_in = 16'd0;
                  case (phase_ff)
                     fwu_pkg::PH_UPDATE_REQ: begin
                        phase_in = fwu_pkg::PH_ID_CHECK;
                        res0 = fwu_pkg::make_reply(fwu_pkg::ACT_REPLY,
                                                   fwu_pkg::RC_UPDATE_OK, 1'b0);
                        res1 = fwu_pkg::make_reply(fwu_pkg::ACT_REPLY,
                                                   fwu_pkg::RC_ID_REQ, 1'b0);
                        res_n = 2'd2;
                     end
                     fwu_pkg::PH_ID_CHECK: begin
                        phase_in = fwu_pkg::PH_LENGTH;
                        res0 = fwu_pkg::make_reply(fwu_pkg::ACT_REPLY,
                                                   fwu_pkg::RC_LEN_REQ, 1'b0);
                        res_n = 2'd1;
                     end
                     default: begin
                        phase_in = fwu_pkg::PH_RECEIVE;
                        res0 = fwu_pkg::make_reply(fwu_pkg::ACT_ERASE, 3'd0, 1'b0);
                        res1 = fwu_pkg::make_reply(fwu_pkg::ACT_REPLY,
                                                   fwu_pkg::RC_READY, 1'b0);
                        res_n = 2'd2;
                     end
                  endcase
               end
            end
         end
      end

      // mark the final result of this item
      if (res_n == 2'd1)
         res0.last_result = 1'b1;
      else if (res_n == 2'd2)
         res1.last_result = 1'b1;
   end

   // session state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= fwu_pkg::PH_SYNC;
         window_ff     <= 32'd0;
         idle_ff       <= 16'd0;
         image_len_ff  <= 32'd0;
         bytes_done_ff <= 32'd0;
         pkt_ok_ff     <= 1'b1;
      end else begin
         phase_ff      <= phase_in;
         window_ff     <= window_in;
         idle_ff       <= idle_in;
         image_len_ff  <= image_len_in;
         bytes_done_ff <= bytes_done_in;
         pkt_ok_ff     <= pkt_ok_in;
      end
   end

   // result queue
   assign pop    = rsp_valid && rsp_ready;
   assign push_n = res_n;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 2'd0;
         tail_ff  <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         head_ff  <= head_ff + {1'b0, pop};
         tail_ff  <= tail_ff + push_n;
         count_ff <= count_ff + {1'b0, push_n} - {2'd0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0)
         q_ff[tail_ff] <= res0;
      if (push_n == 2'd2)
         q_ff[tail_ff + 2'd1] <= res1;
   end

   // result port from queue head
   assign rsp_valid         = (count_ff != 3'd0);
   assign rsp_action        = q_ff[head_ff].action;
   assign rsp_reply_code    = q_ff[head_ff].reply_code;
   assign rsp_write_address = q_ff[head_ff].write_address;
   assign rsp_write_data    = q_ff[head_ff].write_data;
   assign rsp_finished      = q_ff[head_ff].finished;
   assign rsp_last_result   = q_ff[head_ff].last_result;

   // checks
   `FWU_ASSERT_NEXT(a_done_sticky, clock, reset, phase_ff == fwu_pkg::PH_DONE, phase_ff == fwu_pkg::PH_DONE, "session left the done phase")
   `FWU_ASSERT_IMPLIES(a_finish_is_last, clock, reset, rsp_valid && rsp_finished, rsp_last_result, "finishing result not marked last")
   `FWU_ASSERT_IMPLIES(a_sync_clean, clock, reset, phase_ff == fwu_pkg::PH_SYNC, image_len_ff == 32'd0 && bytes_done_ff == 32'd0, "length state changed before sync")
   `FWU_ASSERT_IMPLIES(a_queue_bound, clock, reset, 1'b1, count_ff <= 3'd4, "result queue overflow")

endmodule

// ----- tb/firmware_update_handshake_fsm_unit_tb.sv -----
// self-checking testbench for the firmware update handshake unit: one session per run,
// sync through length checks, then a long random receive phase and a chosen ending
// depends on fwu_pkg and firmware_update_handshake_fsm_unit
module firmware_update_handshake_fsm_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fwu_pkg::*;

   // kind code the block never acts on, reply field when no reply is sent
   localparam logic [1:0] KIND_SPARE   = 2'd3;
   localparam logic [2:0] NO_REPLY     = 3'd0;
   localparam int         DRAIN_CYCLES = 8;
   localparam int         HOLD_CYCLES  = 90;
   localparam int         RUN_LIMIT    = 400000;

   // session tracker: predicts the replies and flash writes, holds them until they arrive
   class update_session_tracker;
      logic [15:0] timeout_ticks;
      logic [7:0]  dev_ident;
      logic [20:0] max_len;
      logic [31:0] app_base;
      logic [7:0]  code_upd;
      logic [7:0]  code_id;
      logic [7:0]  code_len;

      logic [2:0]  phase;
      logic [31:0] sync_window;
      logic [15:0] idle_ticks;
      logic [31:0] image_length;
      logic [31:0] bytes_done;
      bit          packet_good;

      result_type  staged[$];
      result_type  pending[$];
      int          errors;
      int          checked;

      function new();
         timeout_ticks = RST_TIMEOUT;
         dev_ident     = RST_DEV_IDENT;
         max_len       = RST_MAX_LEN;
         app_base      = RST_APP_BASE;
         code_upd      = RST_CODE_UPD;
         code_id       = RST_CODE_ID;
         code_len      = RST_CODE_LEN;
         phase         = PH_SYNC;
         sync_window   = '0;
         idle_ticks    = '0;
         image_length  = '0;
         bytes_done    = '0;
         packet_good   = 1'b1;
         errors        = 0;
         checked       = 0;
      endfunction

      function void set_register(logic [2:0] idx, logic [31:0] val);
         case (idx)
            REG_TIMEOUT:   timeout_ticks = val[15:0];
            REG_DEV_IDENT: dev_ident     = val[7:0];
            REG_MAX_LEN:   max_len       = val[20:0];
            REG_APP_BASE:  app_base      = val;
            REG_CODE_UPD:  code_upd      = val[7:0];
            REG_CODE_ID:   code_id       = val[7:0];
            REG_CODE_LEN:  code_len      = val[7:0];
            default: ;
         endcase
      endfunction

      function void stage(logic [1:0] act, logic [2:0] code, logic [31:0] addr,
                          logic [7:0] data, logic fin);
         result_type r;
         r               = '0;
         r.action        = act;
         r.reply_code    = code;
         r.write_address = addr;
         r.write_data    = data;
         r.finished      = fin;
         staged.push_back(r);
      endfunction

      function void end_with_nack();
         phase = PH_DONE;
         stage(ACT_REPLY, RC_NACK, '0, '0, 1'b1);
      endfunction

      // one byte of a host request packet against its expected layout
      function bit request_byte_ok(logic [7:0] need, logic [7:0] code, logic [3:0] idx,
                                   logic [7:0] val, logic [7:0] lenf);
         if (lenf != need) return 1'b0;
         if (idx == 4'd0) return val == code;
         if ({4'd0, idx} >= need) return val == FILL_BYTE;
         if (phase == PH_ID_CHECK && idx == 4'd1) return val == dev_ident;
         return 1'b1;
      endfunction

      // accepted input transfer: advance the session and queue what it causes
      function void note_request(logic [1:0] kind, logic [7:0] val, logic [3:0] idx,
                                 logic [7:0] lenf, logic last);
         int          cnt;
         int          sh;
         logic [7:0]  need;
         logic [7:0]  code;
         bit          ok;
         staged.delete();
         if (phase >= PH_DONE) return;
         if (kind == KIND_TICK) begin
            if (idle_ticks != TICKS_MAX) idle_ticks++;
            if (idle_ticks >= timeout_ticks) end_with_nack();
         end else if (kind == KIND_RAW) begin
            if (phase == PH_SYNC) begin
               sync_window = {sync_window[23:0], val};
               if (sync_window == SYNC_PATTERN) begin
                  idle_ticks = '0;
                  phase      = PH_UPDATE_REQ;
                  stage(ACT_REPLY, RC_SYNC, '0, '0, 1'b0);
               end
            end
         end else if (kind == KIND_PACKET && phase != PH_SYNC) begin
            if (phase == PH_RECEIVE) begin
               // data packet: flash writes inside the byte count, verdict on the last byte
               cnt = int'(lenf & 8'h1F) + 1;
               if (cnt > int'(PACKET_BYTES)) cnt = int'(PACKET_BYTES);
               if (int'(idx) < cnt)
                  stage(ACT_WRITE, NO_REPLY, app_base + bytes_done + 32'(idx), val, 1'b0);
               if (last) begin
                  bytes_done = bytes_done + 32'(cnt);
                  idle_ticks = '0;
                  if (bytes_done >= image_length) begin
                     phase = PH_DONE;
                     stage(ACT_REPLY, RC_SUCCESS, '0, '0, 1'b1);
                  end else begin
                     stage(ACT_REPLY, RC_READY, '0, '0, 1'b0);
                  end
               end
            end else begin
               // request packets: checked byte by byte, judged on the last byte
               if (phase == PH_UPDATE_REQ) begin
                  need = NEED_UPDATE;
                  code = code_upd;
               end else if (phase == PH_ID_CHECK) begin
                  need = NEED_ID;
                  code = code_id;
               end else begin
                  need = NEED_LENGTH;
                  code = code_len;
               end
               if ({2'd0, idx} < PACKET_BYTES) begin
                  if (!request_byte_ok(need, code, idx, val, lenf)) packet_good = 1'b0;
                  if (phase == PH_LENGTH && idx >= 4'd1 && idx <= 4'd4) begin
                     sh = (int'(idx) - 1) * 8;
                     image_length[sh +: 8] = val;
                  end
               end
               if (last) begin
                  ok          = packet_good;
                  packet_good = 1'b1;
                  if (phase == PH_LENGTH && image_length > {11'd0, max_len}) ok = 1'b0;
                  if (!ok) begin
                     end_with_nack();
                  end else begin
                     idle_ticks = '0;
                     if (phase == PH_UPDATE_REQ) begin
                        phase = PH_ID_CHECK;
                        stage(ACT_REPLY, RC_UPDATE_OK, '0, '0, 1'b0);
                        stage(ACT_REPLY, RC_ID_REQ, '0, '0, 1'b0);
                     end else if (phase == PH_ID_CHECK) begin
                        phase = PH_LENGTH;
                        stage(ACT_REPLY, RC_LEN_REQ, '0, '0, 1'b0);
                     end else begin
                        phase = PH_RECEIVE;
                        stage(ACT_ERASE, NO_REPLY, '0, '0, 1'b0);
                        stage(ACT_REPLY, RC_READY, '0, '0, 1'b0);
                     end
                  end
               end
            end
         end
         if (staged.size() != 0) staged[staged.size() - 1].last_result = 1'b1;
         foreach (staged[k]) pending.push_back(staged[k]);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 50) $display("mismatch at %0t: %s", $time, msg);
      endtask

      // accepted result transfer against the oldest prediction
      task check_response(result_type got);
         result_type want;
         if (pending.size() == 0) begin
            report($sformatf("result with nothing pending: action %0d code %0d addr %h",
                             got.action, got.reply_code, got.write_address));
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.action != want.action)
            report($sformatf("action %0d, want %0d", got.action, want.action));
         if (got.reply_code != want.reply_code)
            report($sformatf("reply_code %0d, want %0d", got.reply_code, want.reply_code));
         if (got.write_address != want.write_address)
            report($sformatf("write_address %h, want %h", got.write_address,
                             want.write_address));
         if (got.write_data != want.write_data)
            report($sformatf("write_data %h, want %h", got.write_data, want.write_data));
         if (got.finished != want.finished)
            report($sformatf("finished %0b, want %0b", got.finished, want.finished));
         if (got.last_result != want.last_result)
            report($sformatf("last_result %0b, want %0b", got.last_result, want.last_result));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_kind;
   logic [7:0]  req_byte_value;
   logic [3:0]  req_byte_index;
   logic [7:0]  req_length_field;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_action;
   logic [2:0]  rsp_reply_code;
   logic [31:0] rsp_write_address;
   logic [7:0]  rsp_write_data;
   logic        rsp_finished;
   logic        rsp_last_result;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   update_session_tracker tracker = new();

   int cycle_count   = 0;
   int items_sent    = 0;
   bit gaps_on       = 1'b1;
   bit calm_tail     = 1'b0;
   bit long_hold_req = 1'b0;

   firmware_update_handshake_fsm_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_byte_value    (req_byte_value),
      .req_byte_index    (req_byte_index),
      .req_length_field  (req_length_field),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_action        (rsp_action),
      .rsp_reply_code    (rsp_reply_code),
      .rsp_write_address (rsp_write_address),
      .rsp_write_data    (rsp_write_data),
      .rsp_finished      (rsp_finished),
      .rsp_last_result   (rsp_last_result),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // cycle count and run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      while (cycle_count < RUN_LIMIT) @(posedge clock);
      $display("run limit of %0d cycles reached, %0d results still pending",
               RUN_LIMIT, tracker.pending.size());
      $display("*** FAILED ***");
      $finish;
   end

   // result side: check every accepted transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_response({rsp_action, rsp_reply_code, rsp_write_address,
                                 rsp_write_data, rsp_finished, rsp_last_result});
   end

   // result side: random stall bursts, one long hold-off on request
   initial begin
      int stall_left;
      int run_left;
      rsp_ready  = 1'b0;
      stall_left = 0;
      run_left   = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (calm_tail || run_left > 0) begin
            rsp_ready = 1'b1;
            if (run_left > 0) run_left--;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready  = 1'b0;
            stall_left = $urandom_range(1, 13) - 1;
         end else begin
            rsp_ready = 1'b1;
            run_left  = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(1, 24);
         end
      end
   end

   // one input transfer, held until accepted
   task automatic send_item(logic [1:0] kind, logic [7:0] val, logic [3:0] idx,
                            logic [7:0] lenf, logic last);
      @(negedge clock);
      req_valid        = 1'b1;
      req_kind         = kind;
      req_byte_value   = val;
      req_byte_index   = idx;
      req_length_field = lenf;
      req_last_byte    = last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(kind, val, idx, lenf, last);
      items_sent++;
   endtask

   // sender gap: drop req_valid, length set by n
   task automatic pause_sender(int n);
      @(negedge clock);
      req_valid = 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic maybe_pause();
      if (!calm_tail && gaps_on && $urandom_range(0, 4) == 0)
         pause_sender($urandom_range(1, 13));
   endtask

   // stop offering, let every pending result arrive and the input stage empty
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write: setup then access cycle
   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = val;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      tracker.set_register(idx, val);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 2))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // random serial byte, tick or spare kind; ticks only while far from the timeout
   task automatic send_noise();
      int pick;
      pick = $urandom_range(0, 2);
      maybe_pause();
      if (pick == 0 && int'(tracker.idle_ticks) + 1 < int'(tracker.timeout_ticks))
         send_item(KIND_TICK, 8'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
      else if (pick == 1)
         send_item(KIND_SPARE, 8'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
      else
         send_item(KIND_RAW, 8'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
   endtask

   // data packet: in order, scattered indexes, or cut off without its last byte
   task automatic send_data_packet(logic [7:0] lenf, int style);
      int cnt;
      int n;
      int i;
      cnt = int'(lenf & 8'h1F) + 1;
      if (cnt > int'(PACKET_BYTES)) cnt = int'(PACKET_BYTES);
      case (style)
         0:       n = cnt;
         1:       n = $urandom_range(1, 6);
         default: n = $urandom_range(1, 4);
      endcase
      for (i = 0; i < n; i++) begin
         maybe_pause();
         if (!calm_tail && $urandom_range(0, 15) == 0) send_noise();
         send_item(KIND_PACKET, 8'($urandom_range(0, 255)),
                   (style == 0) ? 4'(i) : 4'($urandom_range(0, 15)), lenf,
                   style != 2 && i == n - 1);
      end
   endtask

   // new register setting during the receive phase, extremes included
   task automatic retune_registers();
      logic [15:0] ticks;
      logic [31:0] base;
      logic [20:0] limit;
      case ($urandom_range(0, 2))
         0:       ticks = 16'd1;
         1:       ticks = 16'hFFFF;
         default: ticks = 16'($urandom_range(2, 60));
      endcase
      case ($urandom_range(0, 2))
         0:       base = 32'h0;
         1:       base = 32'hFFFFFFFF;
         default: base = $urandom;
      endcase
      case ($urandom_range(0, 2))
         0:       limit = 21'd0;
         1:       limit = 21'h100000;
         default: limit = 21'($urandom_range(0, 21'h100000));
      endcase
      drain_results();
      csr_write(REG_TIMEOUT, {16'd0, ticks});
      csr_write(REG_APP_BASE, base);
      csr_write(REG_MAX_LEN, {11'd0, limit});
      csr_write(REG_DEV_IDENT, {24'd0, pick_byte()});
      csr_write(REG_CODE_UPD, {24'd0, pick_byte()});
      csr_write(REG_CODE_ID, {24'd0, pick_byte()});
      csr_write(REG_CODE_LEN, {24'd0, pick_byte()});
   endtask

   // stimulus
   initial begin
      logic [31:0] length_goal;
      int          last_retune;
      int          style_pick;
      int          i;
      bit          hold_done;
      bit          end_by_success;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = KIND_RAW;
      req_byte_value   = '0;
      req_byte_index   = '0;
      req_length_field = '0;
      req_last_byte    = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      hold_done        = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // first setting: longest timeout, image limit of 2^20, address near the wrap
      csr_write(REG_TIMEOUT, 32'h0000FFFF);
      csr_write(REG_MAX_LEN, 32'h00100000);
      csr_write(REG_APP_BASE, 32'hFFFFFF00 | 32'($urandom_range(0, 255)));
      csr_write(REG_DEV_IDENT, {24'd0, pick_byte()});
      csr_write(REG_CODE_UPD, {24'd0, pick_byte()});
      csr_write(REG_CODE_ID, {24'd0, pick_byte()});
      csr_write(REG_CODE_LEN, {24'd0, pick_byte()});

      // sync phase: a tick, ignored kinds, a near miss, then the pattern
      send_item(KIND_TICK, 8'h00, 4'h0, 8'h00, 1'b0);
      send_item(KIND_SPARE, 8'hFF, 4'hF, 8'hFF, 1'b1);
      send_item(KIND_PACKET, 8'hA5, 4'h3, 8'h01, 1'b1);
      send_item(KIND_RAW, 8'hC4, 4'h0, 8'h00, 1'b0);
      send_item(KIND_RAW, 8'h55, 4'h0, 8'h00, 1'b0);
      send_item(KIND_RAW, 8'h7E, 4'h0, 8'h00, 1'b0);
      send_item(KIND_RAW, 8'h11, 4'h0, 8'h00, 1'b0);
      send_item(KIND_RAW, 8'hC4, 4'h0, 8'h00, 1'b0);
      send_item(KIND_RAW, 8'h55, 4'h0, 8'h00, 1'b0);
      send_item(KIND_RAW, 8'h7E, 4'h0, 8'h00, 1'b0);
      send_item(KIND_RAW, 8'h10, 4'h0, 8'h00, 1'b0);

      // update request with bytes missing, a stray serial byte and a tick inside
      drain_results();
      csr_write(REG_CODE_UPD, {24'd0, pick_byte()});
      send_item(KIND_PACKET, tracker.code_upd, 4'd0, NEED_UPDATE, 1'b0);
      send_item(KIND_RAW, 8'hC4, 4'd0, 8'h00, 1'b0);
      send_item(KIND_TICK, 8'h00, 4'd0, 8'h00, 1'b0);
      send_item(KIND_PACKET, FILL_BYTE, 4'd9, NEED_UPDATE, 1'b0);
      send_item(KIND_PACKET, FILL_BYTE, 4'd15, NEED_UPDATE, 1'b1);

      // device id reply
      drain_results();
      csr_write(REG_DEV_IDENT, {24'd0, pick_byte()});
      send_item(KIND_PACKET, tracker.code_id, 4'd0, NEED_ID, 1'b0);
      send_item(KIND_PACKET, tracker.dev_ident, 4'd1, NEED_ID, 1'b0);
      send_item(KIND_PACKET, FILL_BYTE, 4'd15, NEED_ID, 1'b1);

      // length reply exactly at the limit, lanes out of order
      drain_results();
      length_goal = 32'($urandom_range(900, 1100));
      csr_write(REG_MAX_LEN, length_goal);
      send_item(KIND_PACKET, tracker.code_len, 4'd0, NEED_LENGTH, 1'b0);
      send_item(KIND_PACKET, length_goal[31:24], 4'd4, NEED_LENGTH, 1'b0);
      send_item(KIND_PACKET, length_goal[15:8], 4'd2, NEED_LENGTH, 1'b0);
      send_item(KIND_PACKET, length_goal[23:16], 4'd3, NEED_LENGTH, 1'b0);
      send_item(KIND_PACKET, length_goal[7:0], 4'd1, NEED_LENGTH, 1'b0);
      send_item(KIND_PACKET, FILL_BYTE, 4'd5, NEED_LENGTH, 1'b0);
      send_item(KIND_PACKET, FILL_BYTE, 4'd15, NEED_LENGTH, 1'b1);

      // receive phase: random data packets and noise until the image is nearly done
      last_retune = items_sent;
      while (tracker.phase == PH_RECEIVE &&
             tracker.image_length - tracker.bytes_done > 32'd16) begin
         if (items_sent - last_retune >= 200) begin
            retune_registers();
            last_retune = items_sent;
         end
         if (!hold_done && items_sent > 300) begin
            long_hold_req = 1'b1;
            hold_done     = 1'b1;
         end
         gaps_on   = ($urandom_range(0, 3) != 0);
         calm_tail = (tracker.image_length - tracker.bytes_done < 32'd160);
         style_pick = $urandom_range(0, 9);
         if ($urandom_range(0, 7) == 0)
            send_noise();
         else
            send_data_packet(8'($urandom_range(0, 255)),
                             (style_pick < 6) ? 0 : (style_pick < 9) ? 1 : 2);
      end

      // end the session: either the final packet completes the image or a tick times out
      calm_tail      = 1'b1;
      end_by_success = ($urandom_range(0, 1) == 1);
      if (end_by_success) begin
         send_data_packet(8'h0F, 0);
      end else begin
         drain_results();
         csr_write(REG_TIMEOUT, 32'd1);
         send_item(KIND_TICK, 8'($urandom), 4'($urandom), 8'($urandom), 1'b0);
      end

      // finished session ignores everything
      for (i = 0; i < 8; i++)
         send_item(2'($urandom_range(0, 3)), 8'($urandom), 4'($urandom), 8'($urandom),
                   1'($urandom));

      @(negedge clock);
      req_valid = 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d input transfers, %0d result transfers checked, %0d of %0d image bytes",
               items_sent, tracker.checked, tracker.bytes_done, tracker.image_length);
      $display("session closed by %s, %0d mismatches",
               end_by_success ? "success reply" : "timeout nack", tracker.errors);
      if (tracker.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
